@@ hw/rtl/sbpf_pkg.sv @@
// Shared types and constants for the smooth Bezier path fitter.
// Depends on nothing; every other file but sbpf_queue imports it.
package sbpf_pkg;

   localparam int WIDE_W    = 64;
   localparam int FAC_W     = 30;
   localparam int DEN_W     = 33;
   localparam int DIV_STEPS = WIDE_W + FAC_W;
   localparam int MUL_STEPS = FAC_W;

   localparam logic [DEN_W-1:0] DEN_TWO   = DEN_W'(2) << FAC_W;
   localparam logic [DEN_W-1:0] DEN_THREE = DEN_W'(3) << FAC_W;
   localparam logic [DEN_W-1:0] DEN_FOUR  = DEN_W'(4) << FAC_W;
   localparam logic [DEN_W-1:0] DEN_LAST  = DEN_W'(7) << (FAC_W - 1);
   localparam logic signed [WIDE_W-1:0] FAC_ONE = WIDE_W'(1) << FAC_W;

   typedef enum logic [1:0] {
      CMD_MOVE  = 2'd0,
      CMD_CURVE = 2'd1,
      CMD_LINE  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic store;
      logic emit_move;
      logic flush;
      logic reseed;
      logic corner;
   } entry_ctl_type;

endpackage

@@ hw/rtl/sbpf_queue.sv @@
// Two-entry request queue between the front and back parts of the path fitter.
// Depends on nothing but its own parameter.
module sbpf_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty,
   output logic              full
);

   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/sbpf_front.sv @@
// Front part of the path fitter: accepts knots, tracks the open run and
// classifies each request into a queue entry. Depends on sbpf_pkg.
module sbpf_front import sbpf_pkg::*; #(
   parameter int MAX_RUN_KNOTS = 64,
   parameter int COORD_WIDTH   = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic signed [COORD_WIDTH-1:0]          req_knot_x,
   input  logic signed [COORD_WIDTH-1:0]          req_knot_y,
   input  logic                                   req_is_corner,
   input  logic                                   req_final_knot,
   input  logic                                   queue_full,
   output logic                                   busy,
   output logic                                   push,
   output entry_ctl_type                          push_ctl,
   output logic [$clog2(MAX_RUN_KNOTS)-1:0]       push_idx,
   output logic [$clog2(MAX_RUN_KNOTS)-1:0]       push_spans,
   output logic signed [COORD_WIDTH-1:0]          push_x,
   output logic signed [COORD_WIDTH-1:0]          push_y
);

   localparam int IDX_W = $clog2(MAX_RUN_KNOTS);
   localparam int CNT_W = $clog2(MAX_RUN_KNOTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RUN_KNOTS);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             seen_ff;
   logic             seen_in;
   logic [CNT_W-1:0] count_clip;
   logic [CNT_W-1:0] count_next;
   logic             close_run;

   assign busy   = queue_full;
   assign push   = start && !queue_full;
   assign push_x = req_knot_x;
   assign push_y = req_knot_y;

   always_comb begin
      count_clip = (count_ff >= CNT_MAX) ? CNT_MAX - CNT_W'(1) : count_ff;
      count_next = count_clip + CNT_W'(1);
      close_run  = req_is_corner || req_final_knot || (count_next == CNT_MAX);
      push_ctl   = '0;
      push_idx   = '0;
      push_spans = '0;
      count_in   = count_ff;
      seen_in    = seen_ff;
      if (!seen_ff) begin
         push_ctl.store     = 1'b1;
         push_ctl.emit_move = 1'b1;
         count_in           = req_final_knot ? CNT_W'(0) : CNT_W'(1);
         seen_in            = !req_final_knot;
      end else begin
         push_ctl.store = 1'b1;
         push_idx       = count_clip[IDX_W-1:0];
         if (close_run) begin
            push_ctl.flush  = 1'b1;
            push_ctl.reseed = !req_final_knot;
            push_ctl.corner = req_is_corner;
            push_spans      = count_clip[IDX_W-1:0];
            count_in        = req_final_knot ? CNT_W'(0) : CNT_W'(1);
            seen_in         = !req_final_knot;
         end else begin
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seen_ff  <= 1'b0;
      end else if (push) begin
         count_ff <= count_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

@@ hw/rtl/sbpf_div.sv @@
// Radix-2 restoring divider: truncated sign * (|num| * 2^30 / den).
// Depends on sbpf_pkg.
module sbpf_div import sbpf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WIDE_W-1:0] num,
   input  logic [DEN_W-1:0]         den,
   output logic                     done,
   output logic signed [WIDE_W-1:0] quo
);

   localparam int STEP_W = $clog2(DIV_STEPS + 1);

   logic                   run_ff;
   logic [STEP_W-1:0]      step_ff;
   logic [DIV_STEPS-1:0]   dvd_ff;
   logic [DEN_W-1:0]       rem_ff;
   logic [DEN_W-1:0]       den_ff;
   logic [WIDE_W-1:0]      q_ff;
   logic                   neg_ff;
   logic                   done_ff;
   logic signed [WIDE_W-1:0] quo_ff;
   logic [WIDE_W-1:0]      mag;
   logic [DEN_W:0]         trial;
   logic [DEN_W:0]         diff;
   logic                   ge;
   logic [WIDE_W-1:0]      q_in;

   assign done = done_ff;
   assign quo  = quo_ff;

   always_comb begin
      mag   = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
      trial = {rem_ff, dvd_ff[DIV_STEPS-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = (trial >= {1'b0, den_ff});
      q_in  = {q_ff[WIDE_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
            dvd_ff  <= {mag, FAC_W'(0)};
            rem_ff  <= '0;
            den_ff  <= den;
            q_ff    <= '0;
            neg_ff  <= num[WIDE_W-1];
         end else if (run_ff) begin
            dvd_ff  <= {dvd_ff[DIV_STEPS-2:0], 1'b0};
            rem_ff  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            q_ff    <= q_in;
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
               quo_ff  <= neg_ff ? -$signed(q_in) : $signed(q_in);
            end
         end
      end
   end

endmodule

@@ hw/rtl/sbpf_mul.sv @@
// Shift-and-add multiplier: truncated sign * (|x| * f / 2^30).
// Depends on sbpf_pkg.
module sbpf_mul import sbpf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [WIDE_W-1:0] x,
   input  logic [FAC_W-1:0]         f,
   output logic                     done,
   output logic signed [WIDE_W-1:0] prod
);

   localparam int ACC_W  = WIDE_W + FAC_W;
   localparam int STEP_W = $clog2(MUL_STEPS + 1);

   logic                     run_ff;
   logic [STEP_W-1:0]        step_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic [WIDE_W-1:0]        mag_ff;
   logic [FAC_W-1:0]         f_ff;
   logic                     neg_ff;
   logic                     done_ff;
   logic signed [WIDE_W-1:0] prod_ff;
   logic [ACC_W-1:0]         acc_in;
   logic [WIDE_W-1:0]        res;

   assign done = done_ff;
   assign prod = prod_ff;

   always_comb begin
      acc_in = {acc_ff[ACC_W-2:0], 1'b0}
               + (f_ff[FAC_W-1] ? ACC_W'(mag_ff) : ACC_W'(0));
      res    = acc_in[ACC_W-1:FAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
            acc_ff  <= '0;
            mag_ff  <= x[WIDE_W-1] ? WIDE_W'(-x) : WIDE_W'(x);
            f_ff    <= f;
            neg_ff  <= x[WIDE_W-1];
         end else if (run_ff) begin
            acc_ff  <= acc_in;
            f_ff    <= {f_ff[FAC_W-2:0], 1'b0};
            step_ff <= step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
               prod_ff <= neg_ff ? -$signed(res) : $signed(res);
            end
         end
      end
   end

endmodule

@@ hw/rtl/sbpf_back.sv @@
// Back part of the path fitter: knot and solution memories, the tridiagonal
// solve sequencer and the command emitter. Depends on sbpf_pkg, sbpf_div, sbpf_mul.
module sbpf_back import sbpf_pkg::*; #(
   parameter int MAX_RUN_KNOTS = 64,
   parameter int COORD_WIDTH   = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   q_empty,
   input  entry_ctl_type                          q_ctl,
   input  logic [$clog2(MAX_RUN_KNOTS)-1:0]       q_idx,
   input  logic [$clog2(MAX_RUN_KNOTS)-1:0]       q_spans,
   input  logic signed [COORD_WIDTH-1:0]          q_x,
   input  logic signed [COORD_WIDTH-1:0]          q_y,
   output logic                                   pop,
   output logic                                   rsp_strobe,
   output logic [1:0]                             rsp_command,
   output logic signed [COORD_WIDTH-1:0]          rsp_ctrl1_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_ctrl1_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_ctrl2_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_ctrl2_y,
   output logic signed [COORD_WIDTH-1:0]          rsp_end_x,
   output logic signed [COORD_WIDTH-1:0]          rsp_end_y,
   output logic                                   rsp_run_last
);

   localparam int W     = COORD_WIDTH;
   localparam int IDX_W = $clog2(MAX_RUN_KNOTS);
   localparam logic signed [WIDE_W-1:0] SAT_HI = (WIDE_W'(1) << (W - 1)) - WIDE_W'(1);
   localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

   typedef enum logic [4:0] {
      ST_IDLE, ST_P1_A, ST_P1_B, ST_P1_C, ST_P1_DX, ST_P1_DY,
      ST_SV_INIT, ST_SV_RA, ST_SV_RB, ST_SV_RC, ST_SV_DF, ST_SV_DX,
      ST_BK_A, ST_BK_B, ST_BK_M, ST_EM_A, ST_EM_B, ST_EM_C
   } state_type;

   function automatic logic signed [WIDE_W-1:0] widen(input logic signed [W-1:0] v);
      widen = WIDE_W'(v);
   endfunction

   function automatic logic signed [WIDE_W-1:0] half(input logic signed [WIDE_W-1:0] v);
      half = $signed(v + WIDE_W'(v[WIDE_W-1])) >>> 1;
   endfunction

   function automatic logic signed [W-1:0] sat(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      c = v;
      if (v > SAT_HI) begin
         c = SAT_HI;
      end else if (v < SAT_LO) begin
         c = SAT_LO;
      end
      sat = c[W-1:0];
   endfunction

   logic signed [W-1:0]      kx_mem [MAX_RUN_KNOTS];
   logic signed [W-1:0]      ky_mem [MAX_RUN_KNOTS];
   logic [FAC_W-1:0]         fac_mem [MAX_RUN_KNOTS];
   logic signed [WIDE_W-1:0] sx_mem [MAX_RUN_KNOTS];
   logic signed [WIDE_W-1:0] sy_mem [MAX_RUN_KNOTS];

   logic signed [W-1:0]      kx_rd_ff;
   logic signed [W-1:0]      ky_rd_ff;
   logic [FAC_W-1:0]         fac_rd_ff;
   logic signed [WIDE_W-1:0] sx_rd_ff;
   logic signed [WIDE_W-1:0] sy_rd_ff;

   state_type                state_ff;
   logic [IDX_W-1:0]         n_ff;
   logic [IDX_W-1:0]         i_ff;
   logic [IDX_W-1:0]         j_ff;
   logic                     ax_ff;
   logic                     corner_ff;
   logic                     reseed_ff;
   logic signed [W-1:0]      rx_ff;
   logic signed [W-1:0]      ry_ff;
   logic signed [WIDE_W-1:0] k0x_ff;
   logic signed [WIDE_W-1:0] k0y_ff;
   logic signed [WIDE_W-1:0] k1y_ff;
   logic signed [WIDE_W-1:0] ki_ff;
   logic signed [WIDE_W-1:0] rhs_ff;
   logic [DEN_W-1:0]         b_ff;
   logic signed [WIDE_W-1:0] xprev_ff;
   logic signed [WIDE_W-1:0] sprev_ff;
   logic signed [WIDE_W-1:0] c1x_ff;
   logic signed [WIDE_W-1:0] c1y_ff;
   logic signed [WIDE_W-1:0] ex_ff;
   logic signed [WIDE_W-1:0] ey_ff;

   logic                     rsp_strobe_ff;
   cmd_type                  rsp_command_ff;
   logic signed [W-1:0]      rsp_ctrl1_x_ff;
   logic signed [W-1:0]      rsp_ctrl1_y_ff;
   logic signed [W-1:0]      rsp_ctrl2_x_ff;
   logic signed [W-1:0]      rsp_ctrl2_y_ff;
   logic signed [W-1:0]      rsp_end_x_ff;
   logic signed [W-1:0]      rsp_end_y_ff;
   logic                     rsp_run_last_ff;

   logic [IDX_W-1:0]         ka;
   logic [IDX_W-1:0]         sa;
   logic                     kwe;
   logic [IDX_W-1:0]         kwa;
   logic signed [W-1:0]      kwx;
   logic signed [W-1:0]      kwy;
   logic                     sxe;
   logic                     sye;
   logic [IDX_W-1:0]         swa;
   logic signed [WIDE_W-1:0] swd;
   logic                     fwe;
   logic [FAC_W-1:0]         f_new;
   logic [DEN_W-1:0]         b_new;
   logic signed [WIDE_W-1:0] ksel;
   logic signed [WIDE_W-1:0] rhs_calc;
   logic signed [WIDE_W-1:0] c2x;
   logic signed [WIDE_W-1:0] c2y;
   logic                     last_span;
   logic                     line;

   logic                     div_start;
   logic signed [WIDE_W-1:0] div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     div_done;
   logic signed [WIDE_W-1:0] div_quo;
   logic                     mul_start;
   logic signed [WIDE_W-1:0] mul_x;
   logic [FAC_W-1:0]         mul_f;
   logic                     mul_done;
   logic signed [WIDE_W-1:0] mul_prod;

   sbpf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   sbpf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .x     (mul_x),
      .f     (mul_f),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_command  = rsp_command_ff;
   assign rsp_ctrl1_x  = rsp_ctrl1_x_ff;
   assign rsp_ctrl1_y  = rsp_ctrl1_y_ff;
   assign rsp_ctrl2_x  = rsp_ctrl2_x_ff;
   assign rsp_ctrl2_y  = rsp_ctrl2_y_ff;
   assign rsp_end_x    = rsp_end_x_ff;
   assign rsp_end_y    = rsp_end_y_ff;
   assign rsp_run_last = rsp_run_last_ff;

   always_comb begin
      ksel      = ax_ff ? widen(ky_rd_ff) : widen(kx_rd_ff);
      last_span = (j_ff == n_ff - IDX_W'(1));
      line      = corner_ff && last_span;
      f_new     = div_quo[FAC_W-1:0];
      b_new     = ((i_ff < n_ff - IDX_W'(1)) ? DEN_FOUR : DEN_LAST) - DEN_W'(f_new);
      if (i_ff == '0) begin
         rhs_calc = ki_ff + (ksel <<< 1);
      end else if (i_ff == n_ff - IDX_W'(1)) begin
         rhs_calc = half((ki_ff <<< 3) + ksel);
      end else begin
         rhs_calc = (ki_ff <<< 2) + (ksel <<< 1);
      end
      if (n_ff == IDX_W'(1)) begin
         c2x = (c1x_ff <<< 1) - k0x_ff;
         c2y = (c1y_ff <<< 1) - k0y_ff;
      end else if (!last_span) begin
         c2x = (ex_ff <<< 1) - sx_rd_ff;
         c2y = (ey_ff <<< 1) - sy_rd_ff;
      end else begin
         c2x = half(ex_ff + c1x_ff);
         c2y = half(ey_ff + c1y_ff);
      end

      pop       = 1'b0;
      ka        = '0;
      sa        = '0;
      kwe       = 1'b0;
      kwa       = '0;
      kwx       = q_x;
      kwy       = q_y;
      sxe       = 1'b0;
      sye       = 1'b0;
      swa       = i_ff;
      swd       = div_quo;
      fwe       = 1'b0;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = DEN_TWO;
      mul_start = 1'b0;
      mul_x     = xprev_ff;
      mul_f     = fac_rd_ff;

      unique case (state_ff)
         ST_IDLE: begin
            pop = !q_empty;
            if (!q_empty && q_ctl.store) begin
               kwe = 1'b1;
               kwa = q_idx;
            end
         end
         ST_P1_A: ka = '0;
         ST_P1_B: ka = IDX_W'(1);
         ST_P1_C: begin
            div_start = 1'b1;
            div_num   = (k0x_ff <<< 1) + widen(kx_rd_ff);
            div_den   = DEN_THREE;
         end
         ST_P1_DX: begin
            swa = '0;
            if (div_done) begin
               sxe       = 1'b1;
               div_start = 1'b1;
               div_num   = (k0y_ff <<< 1) + k1y_ff;
               div_den   = DEN_THREE;
            end
         end
         ST_P1_DY: begin
            swa = '0;
            sye = div_done;
         end
         ST_SV_INIT: ka = '0;
         ST_SV_RA: ka = i_ff;
         ST_SV_RB: ka = i_ff + IDX_W'(1);
         ST_SV_RC: begin
            div_start = 1'b1;
            if (i_ff == '0) begin
               div_num = rhs_calc;
               div_den = DEN_TWO;
            end else begin
               div_num = FAC_ONE;
               div_den = b_ff;
            end
         end
         ST_SV_DF: begin
            if (div_done) begin
               fwe       = 1'b1;
               div_start = 1'b1;
               div_num   = rhs_ff - xprev_ff;
               div_den   = b_new;
            end
         end
         ST_SV_DX: begin
            sxe = div_done && !ax_ff;
            sye = div_done && ax_ff;
         end
         ST_BK_A: begin
            ka = i_ff;
            sa = i_ff - IDX_W'(1);
         end
         ST_BK_B: mul_start = 1'b1;
         ST_BK_M: begin
            swa = i_ff - IDX_W'(1);
            swd = sprev_ff - mul_prod;
            sxe = mul_done && !ax_ff;
            sye = mul_done && ax_ff;
         end
         ST_EM_A: begin
            sa = j_ff;
            ka = j_ff + IDX_W'(1);
         end
         ST_EM_B: sa = j_ff + IDX_W'(1);
         ST_EM_C: begin
            if (last_span && reseed_ff) begin
               kwe = 1'b1;
               kwa = '0;
               kwx = rx_ff;
               kwy = ry_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (kwe) begin
         kx_mem[kwa] <= kwx;
         ky_mem[kwa] <= kwy;
      end
      if (fwe) begin
         fac_mem[i_ff] <= f_new;
      end
      if (sxe) begin
         sx_mem[swa] <= swd;
      end
      if (sye) begin
         sy_mem[swa] <= swd;
      end
      kx_rd_ff  <= kx_mem[ka];
      ky_rd_ff  <= ky_mem[ka];
      fac_rd_ff <= fac_mem[ka];
      sx_rd_ff  <= sx_mem[sa];
      sy_rd_ff  <= sy_mem[sa];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_empty) begin
                  if (q_ctl.emit_move) begin
                     rsp_strobe_ff   <= 1'b1;
                     rsp_command_ff  <= CMD_MOVE;
                     rsp_ctrl1_x_ff  <= '0;
                     rsp_ctrl1_y_ff  <= '0;
                     rsp_ctrl2_x_ff  <= '0;
                     rsp_ctrl2_y_ff  <= '0;
                     rsp_end_x_ff    <= q_x;
                     rsp_end_y_ff    <= q_y;
                     rsp_run_last_ff <= 1'b1;
                  end
                  if (q_ctl.flush) begin
                     n_ff      <= q_spans;
                     corner_ff <= q_ctl.corner;
                     reseed_ff <= q_ctl.reseed;
                     rx_ff     <= q_x;
                     ry_ff     <= q_y;
                     j_ff      <= '0;
                     ax_ff     <= 1'b0;
                     state_ff  <= (q_spans == IDX_W'(1)) ? ST_P1_A : ST_SV_INIT;
                  end
               end
            end
            ST_P1_A: state_ff <= ST_P1_B;
            ST_P1_B: begin
               k0x_ff   <= widen(kx_rd_ff);
               k0y_ff   <= widen(ky_rd_ff);
               state_ff <= ST_P1_C;
            end
            ST_P1_C: begin
               k1y_ff   <= widen(ky_rd_ff);
               state_ff <= ST_P1_DX;
            end
            ST_P1_DX: begin
               if (div_done) begin
                  state_ff <= ST_P1_DY;
               end
            end
            ST_P1_DY: begin
               if (div_done) begin
                  j_ff     <= '0;
                  state_ff <= ST_EM_A;
               end
            end
            ST_SV_INIT: begin
               i_ff     <= '0;
               b_ff     <= DEN_TWO;
               xprev_ff <= '0;
               state_ff <= ST_SV_RA;
            end
            ST_SV_RA: state_ff <= ST_SV_RB;
            ST_SV_RB: begin
               ki_ff    <= ksel;
               state_ff <= ST_SV_RC;
            end
            ST_SV_RC: begin
               rhs_ff   <= rhs_calc;
               state_ff <= (i_ff == '0) ? ST_SV_DX : ST_SV_DF;
            end
            ST_SV_DF: begin
               if (div_done) begin
                  b_ff     <= b_new;
                  state_ff <= ST_SV_DX;
               end
            end
            ST_SV_DX: begin
               if (div_done) begin
                  xprev_ff <= div_quo;
                  if (i_ff == n_ff - IDX_W'(1)) begin
                     state_ff <= ST_BK_A;
                  end else begin
                     i_ff     <= i_ff + IDX_W'(1);
                     state_ff <= ST_SV_RA;
                  end
               end
            end
            ST_BK_A: state_ff <= ST_BK_B;
            ST_BK_B: begin
               sprev_ff <= ax_ff ? sy_rd_ff : sx_rd_ff;
               state_ff <= ST_BK_M;
            end
            ST_BK_M: begin
               if (mul_done) begin
                  xprev_ff <= sprev_ff - mul_prod;
                  if (i_ff == IDX_W'(1)) begin
                     if (!ax_ff) begin
                        ax_ff    <= 1'b1;
                        state_ff <= ST_SV_INIT;
                     end else begin
                        j_ff     <= '0;
                        state_ff <= ST_EM_A;
                     end
                  end else begin
                     i_ff     <= i_ff - IDX_W'(1);
                     state_ff <= ST_BK_A;
                  end
               end
            end
            ST_EM_A: state_ff <= ST_EM_B;
            ST_EM_B: begin
               c1x_ff   <= sx_rd_ff;
               c1y_ff   <= sy_rd_ff;
               ex_ff    <= widen(kx_rd_ff);
               ey_ff    <= widen(ky_rd_ff);
               state_ff <= ST_EM_C;
            end
            ST_EM_C: begin
               rsp_strobe_ff   <= 1'b1;
               rsp_command_ff  <= line ? CMD_LINE : CMD_CURVE;
               rsp_ctrl1_x_ff  <= line ? '0 : sat(c1x_ff);
               rsp_ctrl1_y_ff  <= line ? '0 : sat(c1y_ff);
               rsp_ctrl2_x_ff  <= line ? '0 : sat(c2x);
               rsp_ctrl2_y_ff  <= line ? '0 : sat(c2y);
               rsp_end_x_ff    <= ex_ff[W-1:0];
               rsp_end_y_ff    <= ey_ff[W-1:0];
               rsp_run_last_ff <= last_span;
               if (last_span) begin
                  state_ff <= ST_IDLE;
               end else begin
                  j_ff     <= j_ff + IDX_W'(1);
                  state_ff <= ST_EM_A;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_plain_cmd_no_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && (rsp_command_ff == CMD_LINE || rsp_command_ff == CMD_MOVE)
      |-> rsp_ctrl1_x_ff == '0 && rsp_ctrl1_y_ff == '0
          && rsp_ctrl2_x_ff == '0 && rsp_ctrl2_y_ff == '0)
      else $error("line or move command carries control points");

   a_move_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_command_ff == CMD_MOVE |-> rsp_run_last_ff)
      else $error("move command not flagged as last");

   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EM_C |-> j_ff < n_ff)
      else $error("span index beyond run length");

   a_idle_no_unit_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !div_start && !mul_start)
      else $error("arithmetic unit started while idle");

endmodule

@@ hw/rtl/smooth_bezier_path_fitter_top.sv @@
// A knot that does not close a run is taken while the queue is not full and emits nothing;
// a move passes through the queue to the registered outputs of the idle back part. Closing
// a run of n >= 2 spans uses, per axis and knot after the first, two 94-step divisions and
// one 30-step multiply in the shared units; n = 1 uses two divisions only. Commands then
// leave through states EM_A, EM_B and EM_C and cannot be stalled. Reset is synchronous and
// active high and clears the run state and queue; the memories are not cleared.
module smooth_bezier_path_fitter_top import sbpf_pkg::*; #(
   parameter int MAX_RUN_KNOTS = 64,
   parameter int COORD_WIDTH   = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_knot_x,
   input  logic signed [COORD_WIDTH-1:0] req_knot_y,
   input  logic                          req_is_corner,
   input  logic                          req_final_knot,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_command,
   output logic signed [COORD_WIDTH-1:0] rsp_ctrl1_x,
   output logic signed [COORD_WIDTH-1:0] rsp_ctrl1_y,
   output logic signed [COORD_WIDTH-1:0] rsp_ctrl2_x,
   output logic signed [COORD_WIDTH-1:0] rsp_ctrl2_y,
   output logic signed [COORD_WIDTH-1:0] rsp_end_x,
   output logic signed [COORD_WIDTH-1:0] rsp_end_y,
   output logic                          rsp_run_last
);

   localparam int IDX_W  = $clog2(MAX_RUN_KNOTS);
   localparam int DATA_W = $bits(entry_ctl_type) + 2 * IDX_W + 2 * COORD_WIDTH;

   logic                          push;
   entry_ctl_type                 push_ctl;
   logic [IDX_W-1:0]              push_idx;
   logic [IDX_W-1:0]              push_spans;
   logic signed [COORD_WIDTH-1:0] push_x;
   logic signed [COORD_WIDTH-1:0] push_y;
   logic                          pop;
   logic [DATA_W-1:0]             pop_data;
   logic                          q_empty;
   logic                          q_full;
   entry_ctl_type                 q_ctl;
   logic [IDX_W-1:0]              q_idx;
   logic [IDX_W-1:0]              q_spans;
   logic signed [COORD_WIDTH-1:0] q_x;
   logic signed [COORD_WIDTH-1:0] q_y;

   assign {q_ctl, q_idx, q_spans, q_x, q_y} = pop_data;

   sbpf_front #(
      .MAX_RUN_KNOTS (MAX_RUN_KNOTS),
      .COORD_WIDTH   (COORD_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_knot_x     (req_knot_x),
      .req_knot_y     (req_knot_y),
      .req_is_corner  (req_is_corner),
      .req_final_knot (req_final_knot),
      .queue_full     (q_full),
      .busy           (busy),
      .push           (push),
      .push_ctl       (push_ctl),
      .push_idx       (push_idx),
      .push_spans     (push_spans),
      .push_x         (push_x),
      .push_y         (push_y)
   );

   sbpf_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_idx, push_spans, push_x, push_y}),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   sbpf_back #(
      .MAX_RUN_KNOTS (MAX_RUN_KNOTS),
      .COORD_WIDTH   (COORD_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_ctl        (q_ctl),
      .q_idx        (q_idx),
      .q_spans      (q_spans),
      .q_x          (q_x),
      .q_y          (q_y),
      .pop          (pop),
      .rsp_strobe   (rsp_strobe),
      .rsp_command  (rsp_command),
      .rsp_ctrl1_x  (rsp_ctrl1_x),
      .rsp_ctrl1_y  (rsp_ctrl1_y),
      .rsp_ctrl2_x  (rsp_ctrl2_x),
      .rsp_ctrl2_y  (rsp_ctrl2_y),
      .rsp_end_x    (rsp_end_x),
      .rsp_end_y    (rsp_end_y),
      .rsp_run_last (rsp_run_last)
   );

endmodule

@@ verif/smooth_bezier_path_fitter_top_test.sv @@
// Self-checking testbench for the smooth Bezier path fitter: drives knot requests,
// predicts every move, curve and line command, and checks them as they leave the block.
// Depends on sbpf_pkg and smooth_bezier_path_fitter_top.
module smooth_bezier_path_fitter_top_test import sbpf_pkg::*;;

   localparam int RUN_DEPTH = 64;
   localparam int SAT_HI    = 32'h7fffffff;
   localparam int SAT_LO    = 32'h80000000;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct {
      cmd_type   command;
      logic signed [31:0] c1x, c1y, c2x, c2y, ex, ey;
      logic      last;
   } path_cmd_type;

   logic clock, reset, start, busy;
   logic signed [31:0] req_knot_x, req_knot_y;
   logic req_is_corner, req_final_knot;
   logic rsp_strobe, rsp_run_last;
   logic [1:0] rsp_command;
   logic signed [31:0] rsp_ctrl1_x, rsp_ctrl1_y, rsp_ctrl2_x, rsp_ctrl2_y, rsp_end_x, rsp_end_y;

   path_cmd_type pending_cmds[$];
   longint knot_x_mem[RUN_DEPTH], knot_y_mem[RUN_DEPTH];
   longint sol_x_mem[RUN_DEPTH], sol_y_mem[RUN_DEPTH];
   longint unsigned recip_mem[RUN_DEPTH];
   int knots_held;
   bit path_open;
   int errors, knots_sent, cmds_seen, cycles;

   smooth_bezier_path_fitter_top uut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [31:0] clamp32(longint v);
      if (v > longint'(SAT_HI)) return SAT_HI;
      if (v < longint'(SAT_LO)) return SAT_LO;
      return v[31:0];
   endfunction

   function automatic longint scaled_quotient(longint num, longint unsigned den);
      longint unsigned mag, q, r;
      mag = (num < 0) ? -num : num;
      q = mag / den;
      r = mag % den;
      for (int i = 0; i < FAC_W; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r -= den;
            q |= 1;
         end
      end
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint scale_by_recip(longint v, longint unsigned f);
      longint unsigned mag, p;
      mag = (v < 0) ? -v : v;
      p = (mag >> FAC_W) * f + (((mag & ((64'd1 << FAC_W) - 1)) * f) >> FAC_W);
      return (v < 0) ? -longint'(p) : longint'(p);
   endfunction

   task automatic queue_cmd(path_cmd_type pc);
      pending_cmds.insert(pending_cmds.size(), pc);
   endtask

   task automatic solve_controls(int n, bit axis_y);
      longint k[RUN_DEPTH];
      longint rhs[RUN_DEPTH];
      longint s[RUN_DEPTH];
      longint unsigned den, f;
      for (int i = 0; i <= n; i++) k[i] = axis_y ? knot_y_mem[i] : knot_x_mem[i];
      for (int i = 1; i < n - 1; i++) rhs[i] = 4 * k[i] + 2 * k[i + 1];
      rhs[0] = k[0] + 2 * k[1];
      rhs[n - 1] = (8 * k[n - 1] + k[n]) / 2;
      den = DEN_TWO;
      s[0] = scaled_quotient(rhs[0], den);
      for (int i = 1; i < n; i++) begin
         f = (64'd1 << (2 * FAC_W)) / den;
         recip_mem[i] = f;
         den = ((i < n - 1) ? 64'(DEN_FOUR) : 64'(DEN_LAST)) - f;
         s[i] = scaled_quotient(rhs[i] - s[i - 1], den);
      end
      for (int i = 1; i < n; i++) s[n - i - 1] -= scale_by_recip(s[n - i], recip_mem[n - i]);
      for (int i = 0; i < n; i++) begin
         if (axis_y) sol_y_mem[i] = s[i];
         else sol_x_mem[i] = s[i];
      end
   endtask

   task automatic close_run(bit corner_end);
      int n;
      longint c1x, c1y, c2x, c2y;
      path_cmd_type pc;
      n = knots_held - 1;
      if (n >= 2) begin
         solve_controls(n, 0);
         solve_controls(n, 1);
      end
      for (int j = 0; j < n; j++) begin
         if (n == 1) begin
            c1x = (2 * knot_x_mem[0] + knot_x_mem[1]) / 3;
            c1y = (2 * knot_y_mem[0] + knot_y_mem[1]) / 3;
            c2x = 2 * c1x - knot_x_mem[0];
            c2y = 2 * c1y - knot_y_mem[0];
         end else begin
            c1x = sol_x_mem[j];
            c1y = sol_y_mem[j];
            if (j < n - 1) begin
               c2x = 2 * knot_x_mem[j + 1] - sol_x_mem[j + 1];
               c2y = 2 * knot_y_mem[j + 1] - sol_y_mem[j + 1];
            end else begin
               c2x = (knot_x_mem[n] + sol_x_mem[n - 1]) / 2;
               c2y = (knot_y_mem[n] + sol_y_mem[n - 1]) / 2;
            end
         end
         if (corner_end && j == n - 1) begin
            pc.command = CMD_LINE;
            pc.c1x = 0; pc.c1y = 0; pc.c2x = 0; pc.c2y = 0;
         end else begin
            pc.command = CMD_CURVE;
            pc.c1x = clamp32(c1x); pc.c1y = clamp32(c1y);
            pc.c2x = clamp32(c2x); pc.c2y = clamp32(c2y);
         end
         pc.ex = clamp32(knot_x_mem[j + 1]);
         pc.ey = clamp32(knot_y_mem[j + 1]);
         pc.last = (j == n - 1);
         queue_cmd(pc);
      end
   endtask

   task automatic predict_knot(logic signed [31:0] x, logic signed [31:0] y, bit corner, bit fin);
      path_cmd_type pc;
      if (!path_open) begin
         pc.command = CMD_MOVE;
         pc.c1x = 0; pc.c1y = 0; pc.c2x = 0; pc.c2y = 0;
         pc.ex = x; pc.ey = y; pc.last = 1;
         queue_cmd(pc);
         knot_x_mem[0] = x;
         knot_y_mem[0] = y;
         knots_held = fin ? 0 : 1;
         path_open = !fin;
         return;
      end
      if (knots_held >= RUN_DEPTH) knots_held = RUN_DEPTH - 1;
      knot_x_mem[knots_held] = x;
      knot_y_mem[knots_held] = y;
      knots_held++;
      if (!corner && !fin && knots_held < RUN_DEPTH) return;
      close_run(corner);
      if (fin) begin
         knots_held = 0;
         path_open = 0;
      end else begin
         knot_x_mem[0] = x;
         knot_y_mem[0] = y;
         knots_held = 1;
      end
   endtask

   task automatic send_knot(logic signed [31:0] x, logic signed [31:0] y, bit corner, bit fin);
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_knot_x <= x;
      req_knot_y <= y;
      req_is_corner <= corner;
      req_final_knot <= fin;
      do @(posedge clock); while (busy);
      predict_knot(x, y, corner, fin);
      knots_sent++;
   endtask

   task automatic wait_drained();
      start <= 0;
      do @(posedge clock); while (pending_cmds.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return SAT_HI;
         1: return SAT_LO;
         2, 3: return $urandom;
         default: return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
      endcase
   endfunction

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      path_cmd_type pc;
      if (!reset && rsp_strobe) begin
         cmds_seen++;
         if (pending_cmds.size() == 0) begin
            $error("command %0d arrived with none expected", rsp_command);
            errors++;
         end else begin
            pc = pending_cmds.pop_front();
            check_field("command", pc.command, rsp_command);
            check_field("ctrl1_x", pc.c1x, rsp_ctrl1_x);
            check_field("ctrl1_y", pc.c1y, rsp_ctrl1_y);
            check_field("ctrl2_x", pc.c2x, rsp_ctrl2_x);
            check_field("ctrl2_y", pc.c2y, rsp_ctrl2_y);
            check_field("end_x", pc.ex, rsp_end_x);
            check_field("end_y", pc.ey, rsp_end_y);
            check_field("run_last", pc.last, rsp_run_last);
         end
      end
   end

   task automatic test_single_knot_paths();
      send_knot(SAT_HI, SAT_LO, 1, 1);
      send_knot(32'sh00010000, -32'sh00020000, 0, 1);
      wait_drained();
   endtask

   task automatic test_straight_spans();
      send_knot(0, 0, 0, 0);
      send_knot(32'sh00030000, 32'sh00050000, 0, 1);
      send_knot(SAT_LO, SAT_HI, 1, 0);
      send_knot(SAT_HI, SAT_LO, 1, 0);
      send_knot(-32'sh7, 32'sh5, 1, 1);
      wait_drained();
   endtask

   task automatic test_smooth_and_corner_runs();
      send_knot(-32'sh00100000, 32'sh00040000, 0, 0);
      send_knot(32'sh00020000, 32'sh00070000, 0, 0);
      send_knot(32'sh00050000, -32'sh00030000, 0, 0);
      send_knot(32'sh00090000, 32'sh00010000, 1, 0);
      send_knot(SAT_HI, SAT_HI, 0, 0);
      send_knot(SAT_LO, SAT_LO, 0, 0);
      send_knot(SAT_HI, SAT_LO, 0, 0);
      send_knot(-32'sh00010000, 32'sh00080000, 0, 1);
      send_knot(32'sh1, 32'sh2, 0, 0);
      send_knot(32'sh3, 32'sh4, 0, 0);
      send_knot(32'sh5, 32'sh6, 1, 1);
      wait_drained();
   endtask

   task automatic test_full_run_store();
      send_knot(pick_coord(), pick_coord(), 0, 0);
      for (int i = 0; i < RUN_DEPTH + 2; i++)
         send_knot($signed($urandom_range(0, 32'hfffff)), $signed($urandom_range(0, 32'hfffff)),
                   0, i == RUN_DEPTH + 1);
      wait_drained();
   endtask

   task automatic test_random_paths();
      int len;
      while (knots_sent < 110) begin
         if ($urandom_range(0, 4) == 0) begin
            send_knot(pick_coord(), pick_coord(), $urandom_range(0, 1), $urandom_range(0, 3) == 0);
         end else begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
               send_knot(pick_coord(), pick_coord(), $urandom_range(0, 3) == 0, i == len - 1);
         end
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      reset = 1;
      start = 0;
      req_knot_x = 0;
      req_knot_y = 0;
      req_is_corner = 0;
      req_final_knot = 0;
      knots_held = 0;
      path_open = 0;
      errors = 0;
      knots_sent = 0;
      cmds_seen = 0;
      cycles = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_single_knot_paths();
      test_straight_spans();
      test_smooth_and_corner_runs();
      test_full_run_store();
      test_random_paths();
      $display("Sent %0d knots and checked %0d path commands, including a run that filled",
               knots_sent, cmds_seen);
      $display("the store, saturated coordinates and corner, smooth and single-knot paths.");
      if (errors == 0 && pending_cmds.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
